### design/frrts_pkg.sv
// Package for the round-robin / first-come-first-served task scheduler.
// Holds the request and result types, command codes, register indexes and
// the controller-to-datapath command and status structs. No dependencies.
package frrts_pkg;

    localparam int WAIT_DEPTH_DEF = 16;
    localparam int STAMP_W        = 32;
    localparam int ID_W           = 8;
    localparam int LEN_W          = 16;
    localparam int SLICE_W        = 8;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 8;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd5;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_TICKS = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [ID_W-1:0]  task_id;
        logic [LEN_W-1:0] task_length;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]    running_id;
        logic [LEN_W-1:0]   running_left;
        logic [SLICE_W-1:0] slice_left;
        logic               dropped;
        logic               all_done;
    } t_out;

    typedef struct packed {
        logic latch;       // take the incoming request, clear the scan
        logic scan_issue;  // read the next slot of the wait table
        logic fetch;       // read the slot chosen by the scan
        logic apply;       // update table and processor state
        logic out_load;    // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } t_dp_sts;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_FETCH = 6'b001000,
        S_APPLY = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

### design/frrts_ctrl.sv
// Controller state machine of the task scheduler.
// Sequences the table scan, fetch, update and result hand-off.
// Depends on frrts_pkg.
module frrts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  frrts_pkg::t_dp_sts i_sts,
    output frrts_pkg::t_dp_cmd o_cmd
);

    frrts_pkg::t_state r_state, n_state;
    logic r_out_vld, n_out_vld;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            frrts_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = i_sts.need_scan ? frrts_pkg::S_SCAN : frrts_pkg::S_APPLY;
                end
            end
            frrts_pkg::S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = frrts_pkg::S_DRAIN;
                end
            end
            frrts_pkg::S_DRAIN: begin
                n_state = frrts_pkg::S_FETCH;
            end
            frrts_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = frrts_pkg::S_APPLY;
            end
            frrts_pkg::S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = frrts_pkg::S_DONE;
            end
            frrts_pkg::S_DONE: begin
                // The result register must be empty or emptying this cycle.
                if (!r_out_vld || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = frrts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = frrts_pkg::S_IDLE;
            end
        endcase
        n_out_vld = o_cmd.out_load ? 1'b1 : (r_out_vld && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= frrts_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = (r_state != frrts_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

### design/frrts_dpath.sv
// Datapath of the task scheduler: configuration registers, wait table
// memories with valid bits, oldest/free slot scan and processor state.
// Depends on frrts_pkg.
module frrts_dpath #(
    parameter int WAIT_DEPTH = frrts_pkg::WAIT_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [frrts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [frrts_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  frrts_pkg::t_in                      i_in,
    input  frrts_pkg::t_dp_cmd                  i_cmd,
    output frrts_pkg::t_dp_sts                  o_sts,
    output frrts_pkg::t_out                     o_out
);

    localparam int AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam int IW = frrts_pkg::ID_W;
    localparam int LW = frrts_pkg::LEN_W;
    localparam int SW = frrts_pkg::SLICE_W;
    localparam int TW = frrts_pkg::STAMP_W;

    // Wait table payload
    logic [IW-1:0] mem_id    [WAIT_DEPTH];
    logic [LW-1:0] mem_len   [WAIT_DEPTH];
    logic [TW-1:0] mem_stamp [WAIT_DEPTH];

    logic                  r_mode;
    logic [SW-1:0]         r_slice_ticks;
    frrts_pkg::t_in        r_item;
    logic [TW-1:0]         r_now, n_now;
    logic [IW-1:0]         r_run_id, n_run_id;
    logic [LW-1:0]         r_run_rem, n_run_rem;
    logic [SW-1:0]         r_slice, n_slice;
    logic [WAIT_DEPTH-1:0] r_valid, n_valid;
    logic [CW-1:0]         r_vcnt, n_vcnt;
    logic                  r_drop, n_drop;

    logic [AW-1:0]         r_scan_idx;
    logic                  r_cmp_vld;
    logic [AW-1:0]         r_cmp_idx;
    logic                  r_cmp_slot_vld;
    logic                  r_best_found;
    logic [AW-1:0]         r_best_idx;
    logic [TW-1:0]         r_best_stamp;
    logic                  r_free_found;
    logic [AW-1:0]         r_free_idx;

    logic [AW-1:0]         rd_addr;
    logic [IW-1:0]         r_rd_id;
    logic [LW-1:0]         r_rd_len;
    logic [TW-1:0]         r_rd_stamp;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [IW-1:0]         wr_id;
    logic [LW-1:0]         wr_len;
    logic [TW-1:0]         wr_stamp;

    logic [SW-1:0]         slice_load;
    logic [LW-1:0]         rem_dec;
    frrts_pkg::t_out       n_out;
    frrts_pkg::t_out       r_out;

    assign slice_load = (r_slice_ticks == '0) ? SW'(1) : r_slice_ticks;
    assign rem_dec    = (r_run_rem != '0) ? (r_run_rem - LW'(1)) : r_run_rem;

    // Status is taken from the incoming request while the block is idle.
    always_comb begin
        if (i_in.cmd == frrts_pkg::CMD_ARRIVE) begin
            o_sts.need_scan = (i_in.task_id != '0) && (i_in.task_length != '0);
        end else begin
            o_sts.need_scan = (r_run_id == '0) || (r_mode && (r_slice == '0));
        end
        o_sts.scan_last = (r_scan_idx == AW'(WAIT_DEPTH - 1));
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_slice_ticks <= frrts_pkg::SLICE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                frrts_pkg::REG_SCHED_MODE:  r_mode        <= i_cfg_data[0];
                frrts_pkg::REG_SLICE_TICKS: r_slice_ticks <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // Table update and processor state for one request
    always_comb begin
        n_now     = r_now;
        n_run_id  = r_run_id;
        n_run_rem = r_run_rem;
        n_slice   = r_slice;
        n_valid   = r_valid;
        n_vcnt    = r_vcnt;
        n_drop    = r_drop;
        wr_en     = 1'b0;
        wr_addr   = r_free_idx;
        wr_id     = r_item.task_id;
        wr_len    = r_item.task_length;
        wr_stamp  = r_now;
        if (i_cmd.latch) begin
            n_drop = 1'b0;
        end else if (i_cmd.apply) begin
            if (r_item.cmd == frrts_pkg::CMD_ARRIVE) begin
                if ((r_item.task_id != '0) && (r_item.task_length != '0)) begin
                    if (r_free_found) begin
                        wr_en            = 1'b1;
                        n_valid[r_free_idx] = 1'b1;
                        n_vcnt           = r_vcnt + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                end
            end else begin
                n_now = r_now + TW'(1);
                if (r_run_id == '0) begin
                    if (r_best_found) begin
                        n_run_id            = r_rd_id;
                        n_run_rem           = r_rd_len;
                        n_valid[r_best_idx] = 1'b0;
                        n_vcnt              = r_vcnt - CW'(1);
                    end
                    if (r_mode) begin
                        n_slice = slice_load;
                    end
                end else if (r_mode && (r_slice == '0)) begin
                    n_slice = slice_load;
                    // The preempted task takes over the slot that the dispatched task frees.
                    if (r_best_found) begin
                        wr_en     = 1'b1;
                        wr_addr   = r_best_idx;
                        wr_id     = r_run_id;
                        wr_len    = r_run_rem;
                        wr_stamp  = r_now + TW'(1);
                        n_run_id  = r_rd_id;
                        n_run_rem = r_rd_len;
                    end
                end else begin
                    n_run_rem = rem_dec;
                    if (r_mode && (r_slice != '0)) begin
                        n_slice = r_slice - SW'(1);
                    end
                    if (rem_dec == '0) begin
                        n_run_id = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now     <= '0;
            r_run_id  <= '0;
            r_run_rem <= '0;
            r_slice   <= frrts_pkg::SLICE_RESET;
            r_valid   <= '0;
            r_vcnt    <= '0;
            r_drop    <= 1'b0;
        end else begin
            r_now     <= n_now;
            r_run_id  <= n_run_id;
            r_run_rem <= n_run_rem;
            r_slice   <= n_slice;
            r_valid   <= n_valid;
            r_vcnt    <= n_vcnt;
            r_drop    <= n_drop;
        end
    end

    // Scan: one slot read per cycle, each compared in the cycle after its read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx   <= '0;
            r_cmp_vld    <= 1'b0;
            r_best_found <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_issue;
            if (i_cmd.latch) begin
                r_scan_idx   <= '0;
                r_best_found <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (i_cmd.scan_issue) begin
                    r_scan_idx <= r_scan_idx + AW'(1);
                end
                if (r_cmp_vld) begin
                    if (r_cmp_slot_vld &&
                        (!r_best_found || (r_rd_stamp < r_best_stamp))) begin
                        r_best_found <= 1'b1;
                    end
                    if (!r_cmp_slot_vld) begin
                        r_free_found <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in;
        end
        r_cmp_idx      <= r_scan_idx;
        r_cmp_slot_vld <= r_valid[r_scan_idx];
        if (r_cmp_vld) begin
            // Strict compare keeps the lowest index among equal stamps.
            if (r_cmp_slot_vld && (!r_best_found || (r_rd_stamp < r_best_stamp))) begin
                r_best_idx   <= r_cmp_idx;
                r_best_stamp <= r_rd_stamp;
            end
            if (!r_cmp_slot_vld && !r_free_found) begin
                r_free_idx <= r_cmp_idx;
            end
        end
    end

    // Wait table memories: one write and one registered read per cycle.
    assign rd_addr = i_cmd.fetch ? r_best_idx : r_scan_idx;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_id[wr_addr]    <= wr_id;
            mem_len[wr_addr]   <= wr_len;
            mem_stamp[wr_addr] <= wr_stamp;
        end
        r_rd_id    <= mem_id[rd_addr];
        r_rd_len   <= mem_len[rd_addr];
        r_rd_stamp <= mem_stamp[rd_addr];
    end

    // Result register
    always_comb begin
        n_out.running_id   = r_run_id;
        n_out.running_left = (r_run_id != '0) ? r_run_rem : '0;
        n_out.slice_left   = r_mode ? r_slice : '0;
        n_out.dropped      = r_drop;
        n_out.all_done     = (r_run_id == '0) && (r_vcnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

### design/fcfs_round_robin_task_scheduler.sv
// Top level of the first-come-first-served / round-robin task scheduler.
// Joins the controller and the datapath. Depends on frrts_pkg, frrts_ctrl
// and frrts_dpath.
//
// Usage: requests come in on i_in (arrive or tick) with i_in_valid and are
// taken when o_in_stall is low. Every request gives exactly one result on
// o_out with o_out_valid, taken when i_out_stall is low. The configuration
// port writes sched_mode (index 0) and slice_ticks (index 1) whenever
// i_cfg_we is high; it is to be written only while no request is in flight.
// Flow: an arrival with a non-zero id and length, and a tick that must
// dispatch or preempt, scan the whole wait table one slot per cycle through
// the single read port of the table memory, then pass the drain, fetch,
// apply and done states. Ticks that only count down and arrivals that are
// ignored go from idle straight to apply and done. One request is worked
// on at a time; the next is taken in the cycle after the result is loaded.
// A single result register sits on the output: while the receiver stalls,
// the block still takes and works on one more request, then holds until
// the register is free. Reset (synchronous, active low) empties the wait
// table, idles the processor, sets time to zero and the slice to five.
module fcfs_round_robin_task_scheduler #(
    parameter int WAIT_DEPTH = frrts_pkg::WAIT_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [frrts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [frrts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  frrts_pkg::t_in                   i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output frrts_pkg::t_out                  o_out
);

    frrts_pkg::t_dp_cmd dp_cmd;
    frrts_pkg::t_dp_sts dp_sts;

    frrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    frrts_dpath #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out      (o_out)
    );

endmodule
